// File: src/rtv_pkg.sv
package rtv_pkg;

  localparam int CoordWidth   = 32;
  localparam int AngleWidth   = 16;
  localparam int TrigFracBits = 15;
  localparam int TrigWidth    = TrigFracBits + 2;
  localparam int QuadBits     = AngleWidth - 2;

  // word sizes of the serial sine sequencer (Q2.62 fixed point)
  localparam int WordWidth = 64;
  localparam int HalfWidth = 32;
  localparam int AccWidth  = 128;
  localparam int FracQ     = 62;
  localparam logic [WordWidth-1:0] HalfPiQ62 = 64'h6487_ED51_10B4_611A;

  localparam int TermLimit = 20;
  localparam int KWidth    = 5;
  localparam int DvsWidth  = 11;

  localparam int CfgIdxWidth = 2;
  localparam logic [CfgIdxWidth-1:0] CfgAngle   = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgOffsetX = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CfgOffsetY = 2'd2;

  typedef struct packed {
    logic signed [TrigWidth-1:0] cos_v;
    logic signed [TrigWidth-1:0] sin_v;
  } trig_t;

  // (2k)(2k+1), divisor of the k-th series term
  function automatic logic [DvsWidth-1:0] term_divisor(input logic [KWidth-1:0] k);
    logic [KWidth:0]       e;
    logic [2*KWidth+1:0]   p;
    e = {k, 1'b0};
    p = {{(KWidth+1){1'b0}}, e} * {{(KWidth+1){1'b0}}, e | (KWidth+1)'(1)};
    return p[DvsWidth-1:0];
  endfunction

endpackage

// File: src/rtv_trig.sv
module rtv_trig import rtv_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  angle_we_i,
  input  logic [AngleWidth-1:0] angle_i,
  output logic                  busy_o,
  output trig_t                 trig_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMx   = 3'd1;
  localparam logic [2:0] StMx2  = 3'd2;
  localparam logic [2:0] StLoop = 3'd3;
  localparam logic [2:0] StMt   = 3'd4;
  localparam logic [2:0] StDiv  = 3'd5;
  localparam logic [2:0] StAcc  = 3'd6;
  localparam logic [2:0] StFin  = 3'd7;

  localparam logic [5:0] MulLast = 6'd4;
  localparam logic [5:0] DivLast = 6'(WordWidth - 1);
  localparam logic [QuadBits:0] Quarter = {1'b1, {QuadBits{1'b0}}};
  localparam logic [WordWidth-1:0] RoundBit = WordWidth'(1) << (FracQ - 1 - TrigFracBits);

  logic [2:0]              state_q;
  logic [5:0]              cnt_q;
  logic                    run_q;
  logic [KWidth-1:0]       k_q;
  trig_t                   trig_q;

  logic [WordWidth-1:0]    op_a_q, op_b_q;
  logic [AccWidth-1:0]     acc_q;
  logic [WordWidth-1:0]    prod_q;
  logic [1:0]              psh_q;
  logic [WordWidth-1:0]    term_q, sum_q, x2_q, quo_q;
  logic [DvsWidth-1:0]     rem_q;
  logic [QuadBits-1:0]     r_q;
  logic [1:0]              quad_q;
  logic [TrigWidth-1:0]    s_q;

  logic                    mul_st, mul_last, more_terms, div_ge, acc_clr;
  logic [HalfWidth-1:0]    a_part, b_part;
  logic [AccWidth-1:0]     prod_ext, acc_add;
  logic [WordWidth-1:0]    x_new, q62, sum_rnd;
  logic [DvsWidth-1:0]     dvs, rem_nx;
  logic [DvsWidth:0]       rem_sh;
  logic [TrigWidth-1:0]    quad_val;
  trig_t                   trig_new;

  always_comb begin
    mul_st   = (state_q == StMx) || (state_q == StMx2) || (state_q == StMt);
    mul_last = mul_st && (cnt_q == MulLast);
    a_part   = cnt_q[1] ? op_a_q[WordWidth-1:HalfWidth] : op_a_q[HalfWidth-1:0];
    b_part   = cnt_q[0] ? op_b_q[WordWidth-1:HalfWidth] : op_b_q[HalfWidth-1:0];
    case (psh_q)
      2'd0:    prod_ext = {{WordWidth{1'b0}}, prod_q};
      2'd1:    prod_ext = {{HalfWidth{1'b0}}, prod_q, {HalfWidth{1'b0}}};
      default: prod_ext = {prod_q, {WordWidth{1'b0}}};
    endcase
    acc_add    = acc_q + prod_ext;
    x_new      = acc_add[QuadBits+WordWidth-1:QuadBits];
    q62        = acc_add[FracQ+WordWidth-1:FracQ];
    dvs        = term_divisor(k_q);
    rem_sh     = {rem_q, quo_q[WordWidth-1]};
    div_ge     = rem_sh >= {1'b0, dvs};
    rem_nx     = div_ge ? DvsWidth'(rem_sh - {1'b0, dvs}) : rem_sh[DvsWidth-1:0];
    sum_rnd    = sum_q + RoundBit;
    quad_val   = sum_rnd[WordWidth-1 -: TrigWidth];
    more_terms = (k_q < KWidth'(TermLimit)) && (term_q != '0);
    acc_clr    = angle_we_i || ((state_q == StMx) && mul_last) ||
                 ((state_q == StLoop) && more_terms) || ((state_q == StFin) && !run_q);
    case (quad_q)
      2'd0: begin
        trig_new.sin_v = s_q;
        trig_new.cos_v = quad_val;
      end
      2'd1: begin
        trig_new.sin_v = quad_val;
        trig_new.cos_v = -s_q;
      end
      2'd2: begin
        trig_new.sin_v = -s_q;
        trig_new.cos_v = -quad_val;
      end
      default: begin
        trig_new.sin_v = -quad_val;
        trig_new.cos_v = s_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      cnt_q        <= '0;
      run_q        <= 1'b0;
      k_q          <= '0;
      trig_q.cos_v <= TrigWidth'(1) << TrigFracBits;
      trig_q.sin_v <= '0;
    end else if (angle_we_i) begin
      state_q <= StMx;
      cnt_q   <= '0;
      run_q   <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: ;
        StMx: begin
          if (mul_last) begin
            state_q <= StMx2;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        StMx2: begin
          if (mul_last) begin
            state_q <= StLoop;
            k_q     <= KWidth'(1);
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        StLoop: begin
          if (more_terms) begin
            state_q <= StMt;
            cnt_q   <= '0;
          end else begin
            state_q <= StFin;
          end
        end
        StMt: begin
          if (mul_last) begin
            state_q <= StDiv;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        StDiv: begin
          if (cnt_q == DivLast) begin
            state_q <= StAcc;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        StAcc: begin
          k_q     <= k_q + KWidth'(1);
          state_q <= StLoop;
        end
        StFin: begin
          if (!run_q) begin
            run_q   <= 1'b1;
            state_q <= StMx;
            cnt_q   <= '0;
          end else begin
            state_q <= StIdle;
            trig_q  <= trig_new;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_st && (cnt_q != MulLast)) begin
      prod_q <= a_part * b_part;
      psh_q  <= {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
    end
    if (acc_clr) begin
      acc_q <= '0;
    end else if (mul_st && (cnt_q != '0)) begin
      acc_q <= acc_add;
    end
    if (angle_we_i) begin
      r_q    <= angle_i[QuadBits-1:0];
      quad_q <= angle_i[AngleWidth-1 -: 2];
      op_a_q <= WordWidth'(angle_i[QuadBits-1:0]);
      op_b_q <= HalfPiQ62;
    end else begin
      unique case (state_q)
        StMx: begin
          if (mul_last) begin
            term_q <= x_new;
            sum_q  <= x_new;
            op_a_q <= x_new;
            op_b_q <= x_new;
          end
        end
        StMx2: begin
          if (mul_last) begin
            x2_q <= q62;
          end
        end
        StLoop: begin
          if (more_terms) begin
            op_a_q <= term_q;
            op_b_q <= x2_q;
          end
        end
        StMt: begin
          if (mul_last) begin
            quo_q <= q62;
            rem_q <= '0;
          end
        end
        StDiv: begin
          quo_q <= {quo_q[WordWidth-2:0], div_ge};
          rem_q <= rem_nx;
        end
        StAcc: begin
          term_q <= quo_q;
          sum_q  <= k_q[0] ? sum_q - quo_q : sum_q + quo_q;
        end
        StFin: begin
          if (!run_q) begin
            s_q    <= quad_val;
            op_a_q <= WordWidth'(Quarter - {1'b0, r_q});
            op_b_q <= HalfPiQ62;
          end
        end
        default: ;
      endcase
    end
  end

  assign busy_o = (state_q != StIdle);
  assign trig_o = trig_q;

  a_we_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    angle_we_i |=> busy_o)
    else $error("angle write did not start the sine sequencer");

  a_trig_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StFin) |=> $stable(trig_q))
    else $error("sine/cosine changed outside the final step");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |-> (rem_q < dvs))
    else $error("divider remainder not below divisor");

endmodule

// File: src/rtv_pipe.sv
module rtv_pipe import rtv_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         vld_i,
  input  logic signed [CoordWidth-1:0] x_i,
  input  logic signed [CoordWidth-1:0] y_i,
  input  trig_t                        trig_i,
  input  logic signed [CoordWidth-1:0] off_x_i,
  input  logic signed [CoordWidth-1:0] off_y_i,
  output logic                         done_o,
  output logic signed [CoordWidth-1:0] x_o,
  output logic signed [CoordWidth-1:0] y_o,
  output logic                         sat_o
);

  localparam int ProdWidth = TrigWidth + CoordWidth;
  localparam int SumWidth  = ProdWidth + 1;
  localparam int ShWidth   = SumWidth - TrigFracBits;
  localparam int OffWidth  = ShWidth + 1;
  localparam logic signed [SumWidth-1:0] Half = SumWidth'(1) << (TrigFracBits - 1);
  localparam logic [CoordWidth-1:0] CoordMax = {1'b0, {(CoordWidth-1){1'b1}}};
  localparam logic [CoordWidth-1:0] CoordMin = {1'b1, {(CoordWidth-1){1'b0}}};

  function automatic logic [CoordWidth:0] clip(input logic [OffWidth-1:0] v);
    logic hi_ones, hi_zero;
    hi_ones = &v[OffWidth-1:CoordWidth-1];
    hi_zero = ~(|v[OffWidth-1:CoordWidth-1]);
    if (hi_ones || hi_zero) begin
      return {1'b0, v[CoordWidth-1:0]};
    end
    return {1'b1, v[OffWidth-1] ? CoordMin : CoordMax};
  endfunction

  logic [3:0]                   vld_q;
  logic                         done_q;
  logic signed [CoordWidth-1:0] x1_q, y1_q;
  logic signed [ProdWidth-1:0]  pcx_q, psy_q, psx_q, pcy_q;
  logic signed [SumWidth-1:0]   rx_q, ry_q;
  logic signed [OffWidth-1:0]   ox_q, oy_q;
  logic [CoordWidth-1:0]        xo_q, yo_q;
  logic                         sat_q;

  logic signed [TrigWidth-1:0]  cos_s, sin_s;
  logic [CoordWidth:0]          cx, cy;

  always_comb begin
    cos_s = trig_i.cos_v;
    sin_s = trig_i.sin_v;
    cx    = clip(ox_q);
    cy    = clip(oy_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[2:0], vld_i};
      done_q <= vld_q[3];
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q  <= x_i;
    y1_q  <= y_i;
    pcx_q <= ProdWidth'(cos_s) * ProdWidth'(x1_q);
    psy_q <= ProdWidth'(sin_s) * ProdWidth'(y1_q);
    psx_q <= ProdWidth'(sin_s) * ProdWidth'(x1_q);
    pcy_q <= ProdWidth'(cos_s) * ProdWidth'(y1_q);
    rx_q  <= SumWidth'(pcx_q) - SumWidth'(psy_q) + Half;
    ry_q  <= SumWidth'(psx_q) + SumWidth'(pcy_q) + Half;
    ox_q  <= OffWidth'(rx_q >>> TrigFracBits) + OffWidth'(off_x_i);
    oy_q  <= OffWidth'(ry_q >>> TrigFracBits) + OffWidth'(off_y_i);
    xo_q  <= cx[CoordWidth-1:0];
    yo_q  <= cy[CoordWidth-1:0];
    sat_q <= cx[CoordWidth] | cy[CoordWidth];
  end

  assign done_o = done_q;
  assign x_o    = xo_q;
  assign y_o    = yo_q;
  assign sat_o  = sat_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_i |-> ##5 done_o)
    else $error("transfer did not produce a result five cycles later");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(vld_i, 5))
    else $error("result without a matching transfer");

  a_sat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && sat_o) |-> (xo_q == CoordMax || xo_q == CoordMin ||
                           yo_q == CoordMax || yo_q == CoordMin))
    else $error("saturation flagged without a clipped coordinate");

endmodule

// File: src/rotate_translate_vertex.sv
// Channel    Direction  Handshake
// vertex     in         start, busy; transfer when start && !busy
// result     out        done_o strobe, one cycle, no back-pressure
// config     in         cfg_we_i, cfg_idx_i, cfg_data_i; write when cfg_we_i
//
// One vertex per cycle through the multiply, sum, offset and clip stages
// whenever busy is low. An angle write runs the serial sine/cosine sequencer
// (four-step 64-bit multiply, one-bit-per-cycle divide); busy stays high
// until the sequencer finishes.
// Reset: angle 0 (cosine one, sine zero), offsets zero, pipeline empty.
// The result side cannot stall; busy only reflects the sequencer.
module rotate_translate_vertex import rtv_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [CoordWidth-1:0] x_in_i,
  input  logic signed [CoordWidth-1:0] y_in_i,
  input  logic                         cfg_we_i,
  input  logic [CfgIdxWidth-1:0]       cfg_idx_i,
  input  logic [CoordWidth-1:0]        cfg_data_i,
  output logic                         done_o,
  output logic signed [CoordWidth-1:0] x_out_o,
  output logic signed [CoordWidth-1:0] y_out_o,
  output logic                         saturated_o
);

  logic signed [CoordWidth-1:0] off_x_q, off_y_q;
  logic                         angle_we;
  logic                         trig_busy;
  logic                         accept;
  trig_t                        trig;

  assign angle_we = cfg_we_i && (cfg_idx_i == CfgAngle);
  assign accept   = start && !trig_busy;
  assign busy     = trig_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_x_q <= '0;
      off_y_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgOffsetX: off_x_q <= cfg_data_i;
        CfgOffsetY: off_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rtv_trig u_trig (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .angle_we_i (angle_we),
    .angle_i    (cfg_data_i[AngleWidth-1:0]),
    .busy_o     (trig_busy),
    .trig_o     (trig)
  );

  rtv_pipe u_pipe (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (accept),
    .x_i     (x_in_i),
    .y_i     (y_in_i),
    .trig_i  (trig),
    .off_x_i (off_x_q),
    .off_y_i (off_y_q),
    .done_o  (done_o),
    .x_o     (x_out_o),
    .y_o     (y_out_o),
    .sat_o   (saturated_o)
  );

endmodule

// File: verif/rotate_translate_vertex_tb.sv
`timescale 1ns / 1ps

module rotate_translate_vertex_tb;
  import rtv_pkg::*;

  localparam logic [CfgIdxWidth-1:0] CfgUnused = 2'd3;
  localparam logic [63:0] HalfPi = 64'h6487_ED51_10B4_611A;
  localparam int Q62 = 62;
  localparam int NumSettings = 9;
  localparam int ItemsPerSetting = 215;
  localparam longint CoordHi = (longint'(1) <<< (CoordWidth - 1)) - 1;
  localparam longint CoordLo = -CoordHi - 1;
  localparam longint RoundHalf = longint'(1) <<< (TrigFracBits - 1);
  localparam logic signed [CoordWidth-1:0] XMax = CoordHi[CoordWidth-1:0];
  localparam logic signed [CoordWidth-1:0] XMin = CoordLo[CoordWidth-1:0];

  typedef struct packed {
    logic signed [CoordWidth-1:0] x;
    logic signed [CoordWidth-1:0] y;
  } point_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] x;
    logic signed [CoordWidth-1:0] y;
    logic                         sat;
  } vertex_t;

  logic                         clk_i;
  logic                         rst_ni = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  logic signed [CoordWidth-1:0] x_in_i = '0;
  logic signed [CoordWidth-1:0] y_in_i = '0;
  logic                         cfg_we_i = 1'b0;
  logic [CfgIdxWidth-1:0]       cfg_idx_i = '0;
  logic [CoordWidth-1:0]        cfg_data_i = '0;
  logic                         done_o;
  logic signed [CoordWidth-1:0] x_out_o;
  logic signed [CoordWidth-1:0] y_out_o;
  logic                         saturated_o;

  rotate_translate_vertex i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .x_in_i      (x_in_i),
    .y_in_i      (y_in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .done_o      (done_o),
    .x_out_o     (x_out_o),
    .y_out_o     (y_out_o),
    .saturated_o (saturated_o)
  );

  // transform state as the block should hold it
  trig_t                        trig = '{cos_v: TrigWidth'(1 << TrigFracBits), sin_v: '0};
  logic signed [CoordWidth-1:0] off_x = '0;
  logic signed [CoordWidth-1:0] off_y = '0;

  point_t  vertex_q[$];
  vertex_t transformed_q[$];
  int      xfer_cnt = 0;
  int      popped_cnt = 0;
  int      idle_pct = 0;
  int      errors = 0;
  int      clipped_cnt = 0;

  function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return p[Q62+63:Q62];
  endfunction

  // round(sin(r * pi/2 / quarter turn) * 2^F) by Taylor series in Q2.62
  function automatic logic signed [TrigWidth-1:0] quarter_sine(input logic [QuadBits:0] r);
    logic [127:0] p;
    logic [63:0]  xv, x2, term, acc;
    int           k;
    p = 128'(r) * 128'(HalfPi);
    xv = p[QuadBits+63:QuadBits];
    x2 = q62_mul(xv, xv);
    term = xv;
    acc = xv;
    for (k = 1; k < 20 && term != 0; k++) begin
      term = q62_mul(term, x2) / 64'((2 * k) * (2 * k + 1));
      if ((k % 2) == 1) acc -= term;
      else acc += term;
    end
    acc += 64'd1 << (Q62 - 1 - TrigFracBits);
    acc = acc >> (Q62 - TrigFracBits);
    return acc[TrigWidth-1:0];
  endfunction

  function automatic trig_t angle_to_trig(input logic [AngleWidth-1:0] a);
    logic [QuadBits:0]           r;
    logic signed [TrigWidth-1:0] s, c;
    trig_t                       t;
    r = {1'b0, a[QuadBits-1:0]};
    s = quarter_sine(r);
    c = quarter_sine((QuadBits + 1)'(1 << QuadBits) - r);
    case (a[AngleWidth-1:QuadBits])
      2'd0: begin
        t.sin_v = s;
        t.cos_v = c;
      end
      2'd1: begin
        t.sin_v = c;
        t.cos_v = -s;
      end
      2'd2: begin
        t.sin_v = -s;
        t.cos_v = -c;
      end
      default: begin
        t.sin_v = -c;
        t.cos_v = s;
      end
    endcase
    return t;
  endfunction

  function automatic logic signed [CoordWidth-1:0] clip_coord(input longint v,
                                                             inout logic sat);
    if (v > CoordHi) begin
      sat = 1'b1;
      return XMax;
    end
    if (v < CoordLo) begin
      sat = 1'b1;
      return XMin;
    end
    return v[CoordWidth-1:0];
  endfunction

  function automatic vertex_t transform_vertex(input logic signed [CoordWidth-1:0] xv,
                                               input logic signed [CoordWidth-1:0] yv);
    longint  c, s, rx, ry;
    vertex_t v;
    logic    sat;
    c = longint'($signed(trig.cos_v));
    s = longint'($signed(trig.sin_v));
    rx = c * longint'(xv) - s * longint'(yv) + RoundHalf;
    ry = s * longint'(xv) + c * longint'(yv) + RoundHalf;
    rx = (rx >>> TrigFracBits) + longint'(off_x);
    ry = (ry >>> TrigFracBits) + longint'(off_y);
    sat = 1'b0;
    v.x = clip_coord(rx, sat);
    v.y = clip_coord(ry, sat);
    v.sat = sat;
    return v;
  endfunction

  function automatic logic signed [CoordWidth-1:0] rand_coord();
    case ($urandom_range(9))
      0: return XMax;
      1: return XMin;
      2: return CoordWidth'($urandom_range(4095)) - CoordWidth'(2048);
      default: return CoordWidth'($urandom());
    endcase
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("rotate_translate_vertex_tb: done, errors");
    $finish;
  end

  // driver: present the head of the queue, idling at random
  always @(negedge clk_i) begin : driver
    logic go;
    if (popped_cnt < xfer_cnt) begin
      void'(vertex_q.pop_front());
      popped_cnt++;
    end
    go = rst_ni && vertex_q.size() != 0 && $urandom_range(99) >= idle_pct;
    start <= go;
    if (go) begin
      x_in_i <= vertex_q[0].x;
      y_in_i <= vertex_q[0].y;
    end else begin
      x_in_i <= CoordWidth'($urandom());
      y_in_i <= CoordWidth'($urandom());
    end
  end

  // monitor: check each result against the oldest prediction
  always @(posedge clk_i) begin : monitor
    vertex_t want;
    if (rst_ni) begin
      if (done_o !== 1'b0) begin
        if (transformed_q.size() == 0) begin
          $display("%0t: result with none expected: x %0d y %0d sat %b",
                   $time, x_out_o, y_out_o, saturated_o);
          errors++;
        end else begin
          want = transformed_q.pop_front();
          if (x_out_o !== want.x) begin
            $display("%0t: x_out expected %0d got %0d", $time, want.x, x_out_o);
            errors++;
          end
          if (y_out_o !== want.y) begin
            $display("%0t: y_out expected %0d got %0d", $time, want.y, y_out_o);
            errors++;
          end
          if (saturated_o !== want.sat) begin
            $display("%0t: saturated expected %b got %b", $time, want.sat, saturated_o);
            errors++;
          end
          if (want.sat) clipped_cnt++;
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        transformed_q.push_back(transform_vertex(x_in_i, y_in_i));
        xfer_cnt++;
      end
    end
  end

  task automatic drain();
    while (vertex_q.size() != 0 || transformed_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx,
                           input logic [CoordWidth-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_data_i <= CoordWidth'($urandom());
    case (idx)
      CfgAngle:   trig = angle_to_trig(data[AngleWidth-1:0]);
      CfgOffsetX: off_x = data;
      CfgOffsetY: off_y = data;
      default: ;
    endcase
  endtask

  initial begin : stimulus
    logic [CoordWidth-1:0] ang, ox, oy;
    point_t                pt;
    int                    s, n;
    point_t                corners[12];
    corners = '{'{'0, '0}, '{XMax, XMax}, '{XMin, XMin}, '{XMax, XMin},
                '{XMin, XMax}, '{-1, -1}, '{1, 1}, '{-1, 1}, '{XMax, '0},
                '{'0, XMin}, '{256, -256}, '{1, '0}};
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    for (s = 0; s < NumSettings; s++) begin
      idle_pct = (s < 3) ? 13 : (s < 6) ? 75 : 0;
      if (s == 0) begin
        foreach (corners[i]) vertex_q.push_back(corners[i]);
      end else begin
        drain();
        repeat (2) @(negedge clk_i);
        case (s)
          1: begin ang = 32'h0000_4000; ox = XMax;               oy = XMin;               end
          2: begin ang = 32'hA5A5_8000; ox = XMin;               oy = XMax;               end
          3: begin ang = 32'h0000_7FFF; ox = $urandom();         oy = $urandom();         end
          4: begin ang = 32'hFFFF_C000; ox = '0;                 oy = '0;                 end
          5: begin ang = 32'h0000_2000; ox = XMax;               oy = XMax;               end
          6: begin ang = 32'h0000_0001; ox = $urandom();         oy = $urandom();         end
          7: begin ang = $urandom();    ox = $urandom();         oy = $urandom();         end
          default: begin ang = 32'h0001_0000; ox = '1;           oy = 32'd1;              end
        endcase
        write_reg(CfgOffsetX, ox);
        write_reg(CfgOffsetY, oy);
        if (s == 4) write_reg(CfgUnused, $urandom());
        write_reg(CfgAngle, ang);
        while (busy !== 1'b0) @(negedge clk_i);
      end
      for (n = 0; n < ItemsPerSetting; n++) begin
        // hold off once until the pipeline is empty
        if (s == 4 && n == ItemsPerSetting / 2) drain();
        pt.x = rand_coord();
        pt.y = rand_coord();
        vertex_q.push_back(pt);
        while (vertex_q.size() > 4) @(negedge clk_i);
      end
    end
    drain();
    repeat (20) @(negedge clk_i);
    $display("%0d vertices transferred over %0d transform settings, %0d clipped",
             xfer_cnt, NumSettings, clipped_cnt);
    if (errors == 0) $display("rotate_translate_vertex_tb: done, clean");
    else $display("rotate_translate_vertex_tb: done, errors");
    $finish;
  end

endmodule
